### rtl/core/b64v_pkg.sv
// Shared types and constants for the base64 variant encoder.
// Depends on nothing; imported by every module of the block.
package b64v_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_SYM62 = 2'd0;
  localparam logic [1:0] REG_SYM63 = 2'd1;
  localparam logic [1:0] REG_PAD   = 2'd2;

  localparam logic [7:0] SYM62_RESET = 8'd46;
  localparam logic [7:0] SYM63_RESET = 8'd45;
  localparam logic [7:0] PAD_RESET   = 8'd42;

  localparam logic [7:0] TERM_CHAR = 8'd0;

  // Character positions within one command
  localparam logic [2:0] POS_C0   = 3'd0;
  localparam logic [2:0] POS_C1   = 3'd1;
  localparam logic [2:0] POS_C2   = 3'd2;
  localparam logic [2:0] POS_C3   = 3'd3;
  localparam logic [2:0] POS_TERM = 3'd4;

  // One unit of output work: an optional group of one to three bytes,
  // followed by an optional terminator.
  typedef struct packed {
    logic       grp_valid;
    logic [1:0] grp_len;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic       term;
  } cmd_t;

  function automatic logic [7:0] sextet_char(input logic [5:0] v,
                                             input logic [7:0] s62,
                                             input logic [7:0] s63);
    logic [7:0] r;
    if (v < 6'd26) begin
      r = 8'd65 + {2'b00, v};
    end else if (v < 6'd52) begin
      r = 8'd97 + {2'b00, v - 6'd26};
    end else if (v < 6'd62) begin
      r = 8'd48 + {2'b00, v - 6'd52};
    end else if (v == 6'd62) begin
      r = s62;
    end else begin
      r = s63;
    end
    return r;
  endfunction

endpackage

### rtl/core/b64v_front.sv
// Front end: accepts message bytes, holds pending bytes, and turns each item
// into at most one command. Depends on b64v_pkg.
module b64v_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      data_byte,
  input  logic            end_of_message,
  input  logic            q_full,
  output logic            q_push,
  output b64v_pkg::cmd_t  q_wdata
);
  import b64v_pkg::*;

  logic [7:0] p0;
  logic [7:0] p1;
  logic [1:0] cnt;
  logic       stopped;

  logic [7:0] p0_next;
  logic [7:0] p1_next;
  logic [1:0] cnt_mid;
  logic [1:0] cnt_next;
  logic       stopped_mid;
  logic       stopped_next;
  logic       accept;
  cmd_t       cmd;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd          = '0;
    cmd.b0       = p0;
    cmd.term     = end_of_message;
    p0_next      = p0;
    p1_next      = p1;
    cnt_mid      = cnt;
    stopped_mid  = stopped;
    if (!stopped) begin
      if (data_byte == 8'd0) begin
        // flush whatever is pending, then stop the message
        if (cnt != 2'd0) begin
          cmd.grp_valid = 1'b1;
          cmd.grp_len   = cnt;
          cmd.b1        = (cnt == 2'd2) ? p1 : 8'd0;
        end
        cnt_mid     = 2'd0;
        stopped_mid = 1'b1;
      end else if (cnt == 2'd2) begin
        cmd.grp_valid = 1'b1;
        cmd.grp_len   = 2'd3;
        cmd.b1        = p1;
        cmd.b2        = data_byte;
        cnt_mid       = 2'd0;
      end else begin
        if (cnt == 2'd0) begin
          p0_next = data_byte;
        end else begin
          p1_next = data_byte;
        end
        cnt_mid = cnt + 2'd1;
      end
    end
    cnt_next     = cnt_mid;
    stopped_next = stopped_mid;
    if (end_of_message) begin
      // final flush of the bytes left after this one
      if (cnt_mid != 2'd0) begin
        cmd.grp_valid = 1'b1;
        cmd.grp_len   = cnt_mid;
        cmd.b0        = p0_next;
        cmd.b1        = (cnt_mid == 2'd2) ? p1_next : 8'd0;
        cmd.b2        = 8'd0;
      end
      cnt_next     = 2'd0;
      stopped_next = 1'b0;
    end
  end

  assign q_push  = accept && (cmd.grp_valid || cmd.term);
  assign q_wdata = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= 2'd0;
      stopped <= 1'b0;
    end else if (accept) begin
      cnt     <= cnt_next;
      stopped <= stopped_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p0 <= p0_next;
      p1 <= p1_next;
    end
  end

endmodule

### rtl/core/b64v_queue.sv
// Small command queue between front and back end.
// Depends on b64v_pkg for the command type.
module b64v_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  b64v_pkg::cmd_t  wdata,
  input  logic            pop,
  output b64v_pkg::cmd_t  rdata,
  output logic            full,
  output logic            empty
);
  import b64v_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

### rtl/core/b64v_back.sv
// Back end: walks each command one character per cycle, while the output is
// not stalled by out_ready, into the output register. Depends on b64v_pkg.
module b64v_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  input  b64v_pkg::cmd_t  q_rdata,
  output logic            q_pop,
  input  logic [7:0]      sym62,
  input  logic [7:0]      sym63,
  input  logic [7:0]      pad,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      text_char,
  output logic            end_of_text
);
  import b64v_pkg::*;

  cmd_t       cur;
  logic       busy;
  logic [2:0] pos;

  logic       advance;
  logic       last;
  logic [7:0] ch;
  logic [2:0] start_pos;

  assign advance   = busy && (!out_valid || out_ready);
  assign last      = (pos == POS_TERM) || (pos == POS_C3 && !cur.term);
  assign q_pop     = !q_empty && (!busy || (advance && last));
  assign start_pos = q_rdata.grp_valid ? POS_C0 : POS_TERM;

  always_comb begin
    case (pos)
      POS_C0:  ch = sextet_char(cur.b0[7:2], sym62, sym63);
      POS_C1:  ch = sextet_char({cur.b0[1:0], cur.b1[7:4]}, sym62, sym63);
      POS_C2:  ch = (cur.grp_len < 2'd2) ? pad
                    : sextet_char({cur.b1[3:0], cur.b2[7:6]}, sym62, sym63);
      POS_C3:  ch = (cur.grp_len < 2'd3) ? pad
                    : sextet_char(cur.b2[5:0], sym62, sym63);
      default: ch = TERM_CHAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pos       <= POS_C0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        busy <= 1'b1;
        pos  <= start_pos;
      end else if (advance) begin
        if (last) begin
          busy <= 1'b0;
        end else if (pos == POS_C3) begin
          pos <= POS_TERM;
        end else begin
          pos <= pos + 3'd1;
        end
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_rdata;
    end
    if (advance) begin
      text_char   <= ch;
      end_of_text <= (pos == POS_TERM);
    end
  end

endmodule

### rtl/core/base64_variant_encoder_top.sv
// Base64 variant encoder with a configurable alphabet tail and pad character:
// top level. Depends on b64v_pkg, b64v_front, b64v_queue and b64v_back.
//
// Each input item carries one message byte and an end-of-message mark. Every
// third byte completes a group that leaves as four characters, one character
// per cycle while the output channel is ready; a final partial group is
// zero-filled and its missing positions carry the pad character. A zero byte
// ends the message early: pending bytes are flushed and later bytes are
// dropped until the end mark, which always yields a zero terminator with
// end_of_text set. The front end accepts a byte in any cycle in which the
// command queue has room. The output port sets the sustained rate: four
// characters per three bytes, and up to five characters for a byte that
// ends a message.
// Register writes (index 0: character for value 62, 1: character for value
// 63, 2: pad character, other indexes dropped) take effect at once and
// belong between messages while the block is idle.

module base64_variant_encoder_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       end_of_message,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] text_char,
  output logic       end_of_text,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import b64v_pkg::*;

  logic [7:0] sym62;
  logic [7:0] sym63;
  logic [7:0] pad;

  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  cmd_t q_wdata;
  cmd_t q_rdata;

  // Configuration registers: hold until rewritten
  always_ff @(posedge clk) begin
    if (rst) begin
      sym62 <= SYM62_RESET;
      sym63 <= SYM63_RESET;
      pad   <= PAD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SYM62: sym62 <= cfg_data;
        REG_SYM63: sym63 <= cfg_data;
        REG_PAD:   pad   <= cfg_data;
        default:   ;
      endcase
    end
  end

  // Front: classify each byte into a group and/or terminator command
  b64v_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .end_of_message (end_of_message),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_wdata        (q_wdata)
  );

  // Queue: decouple byte intake from character output
  b64v_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  // Back: serialize characters into the output register
  b64v_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_rdata     (q_rdata),
    .q_pop       (q_pop),
    .sym62       (sym62),
    .sym63       (sym63),
    .pad         (pad),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .text_char   (text_char),
    .end_of_text (end_of_text)
  );

  // The terminator always carries a zero character
  a_term_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_text |-> text_char == TERM_CHAR)
    else $error("terminator carries a nonzero character");

  // Never pop an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("command queue popped while empty");

  // An accepted end mark always queues a command for its terminator
  a_eom_pushes: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && end_of_message |-> q_push && q_wdata.term)
    else $error("end of message produced no terminator command");

endmodule
